// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the RTL of the tag nesting checker.
// No dependencies; taken in by `include where a module asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, held off while reset is low
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression that must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== rtl/core/mtnc_pkg.sv =====
// Package for the markup tag nesting checker: character codes, beat widths
// and the white-space test. No dependencies.
package mtnc_pkg;

  // Characters that steer the parser
  localparam logic [7:0] CH_LT       = 8'h3C;  // '<'
  localparam logic [7:0] CH_QUESTION = 8'h3F;  // '?'
  localparam logic [7:0] CH_BANG     = 8'h21;  // '!'
  localparam logic [7:0] CH_SLASH    = 8'h2F;  // '/'
  localparam logic [7:0] CH_GT       = 8'h3E;  // '>'
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_CR       = 8'h0D;

  // Beat widths
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 8;

  // Space, or tab through carriage return
  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

endpackage

// ===== rtl/core/mtnc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mtnc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port (read returns old data on a clash)
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/markup_tag_nesting_checker_top.sv =====
// The verdict for a beat with tlast set is valid on the master side once that beat
// has been accepted and has passed the input register and then the result register.
// Throughput: one beat per cycle; a tlast beat waits in the input register only
// while the previous verdict is still held by a low m_axis_tready.
// Reset: rst_ni clears all control state at once; store contents stay
// undefined and are never read before they are written.
// Depends on mtnc_pkg, mtnc_ram and assert_macros.svh.
module markup_tag_nesting_checker_top
  import mtnc_pkg::*;
#(
  parameter int unsigned MAX_DEPTH    = 16,
  parameter int unsigned MAX_NAME_LEN = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Slave side
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic                s_axis_tuser,   // [0] byte_present
  input  logic                s_axis_tlast,   // end_of_document
  // Master side
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata    // [0] well_formed, [1] capacity_exceeded,
                                              // [7:2] zero
);

  localparam int unsigned DepthW = $clog2(MAX_DEPTH + 1);
  localparam int unsigned TopW   = $clog2(MAX_DEPTH);
  localparam int unsigned LenW   = $clog2(MAX_NAME_LEN + 1);
  localparam int unsigned ColW   = $clog2(MAX_NAME_LEN);
  localparam int unsigned NameD  = MAX_DEPTH * MAX_NAME_LEN;
  localparam int unsigned NameAw = $clog2(NameD);

  typedef enum logic [2:0] {
    PH_OUTSIDE  = 3'd0,
    PH_AFTER_LT = 3'd1,
    PH_PI       = 3'd2,
    PH_BANG     = 3'd3,
    PH_NAME     = 3'd4,
    PH_ATTR     = 3'd5,
    PH_SLASH    = 3'd6
  } phase_e;

  // Input register
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_pres_q;
  logic       in_end_q;
  logic       advance;

  // Parser state
  phase_e            phase_q, phase_d;
  logic              qseen_q, qseen_d;
  logic              closing_q, closing_d;
  logic [LenW-1:0]   len_q, len_d;
  logic              mism_q, mism_d;
  logic [DepthW-1:0] depth_q, depth_d;
  logic [1:0]        root_q, root_d;
  logic              failed_q, failed_d;
  logic              ovf_q, ovf_d;

  // Result register
  logic       out_vld_q, out_vld_d;
  logic       wf_q, wf_d;
  logic       cap_q, cap_d;

  // Store ports
  logic              name_we;
  logic [NameAw-1:0] name_waddr, name_raddr;
  logic [7:0]        name_rd;
  logic              len_we;
  logic [TopW-1:0]   len_waddr, len_raddr;
  logic [LenW-1:0]   len_rd;
  logic              byp_q;
  logic [LenW-1:0]   byp_data_q;
  logic [LenW-1:0]   top_len;

  // Handshake: the input stage drains unless an end beat's verdict waits on a full output
  assign advance       = in_vld_q && (!in_end_q || !out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  // Top-of-stack length, with a bypass for a push written in the last cycle
  assign top_len = byp_q ? byp_data_q : len_rd;

  // Per-byte parser step, verdict and end-of-document reset
  always_comb begin
    logic       proc;
    logic       do_name_phase;
    logic       do_finish;
    logic       self_close;
    logic       cut_off;
    logic [7:0] b;
    phase_d       = phase_q;
    qseen_d       = qseen_q;
    closing_d     = closing_q;
    len_d         = len_q;
    mism_d        = mism_q;
    depth_d       = depth_q;
    root_d        = root_q;
    failed_d      = failed_q;
    ovf_d         = ovf_q;
    out_vld_d     = out_vld_q && !m_axis_tready;
    wf_d          = wf_q;
    cap_d         = cap_q;
    name_we       = 1'b0;
    len_we        = 1'b0;
    do_name_phase = 1'b0;
    do_finish     = 1'b0;
    self_close    = 1'b0;
    cut_off       = 1'b0;
    b             = in_byte_q;
    proc          = advance && in_pres_q && !failed_q;

    if (proc) begin
      unique case (phase_q)
        PH_OUTSIDE: begin
          if (b == CH_LT) phase_d = PH_AFTER_LT;
        end
        PH_AFTER_LT: begin
          if (b == CH_QUESTION) begin
            phase_d = PH_PI;
            qseen_d = 1'b1;
          end else if (b == CH_BANG) begin
            phase_d = PH_BANG;
          end else if (b == CH_SLASH) begin
            closing_d = 1'b1;
            phase_d   = PH_NAME;
          end else begin
            do_name_phase = 1'b1;
          end
        end
        PH_PI: begin
          if (qseen_q && (b == CH_GT)) begin
            qseen_d = 1'b0;
            phase_d = PH_OUTSIDE;
          end else begin
            qseen_d = (b == CH_QUESTION);
          end
        end
        PH_BANG: begin
          if (b == CH_GT) phase_d = PH_OUTSIDE;
        end
        PH_NAME: begin
          do_name_phase = 1'b1;
        end
        PH_ATTR: begin
          if (b == CH_GT) begin
            do_finish = 1'b1;
          end else if (b == CH_SLASH) begin
            phase_d = PH_SLASH;
          end
        end
        PH_SLASH: begin
          if (b == CH_GT) begin
            do_finish  = 1'b1;
            self_close = 1'b1;
          end else begin
            failed_d = 1'b1;
          end
        end
        default: failed_d = 1'b1;
      endcase
    end

    // Byte inside or at the start of a tag name
    if (do_name_phase) begin
      if (b == CH_GT) begin
        do_finish = 1'b1;
      end else if (b == CH_SLASH) begin
        phase_d = PH_SLASH;
      end else if (is_space(b)) begin
        phase_d = PH_ATTR;
      end else begin
        phase_d = PH_NAME;
        if (closing_q) begin
          // compare against the byte of the top name, read ahead through the registered store port
          if (depth_q == '0) begin
            mism_d = 1'b1;
          end else if ((len_q >= top_len) || (len_q >= LenW'(MAX_NAME_LEN)) ||
                       (name_rd != b)) begin
            mism_d = 1'b1;
          end
          if (len_q < LenW'(MAX_NAME_LEN)) len_d = len_q + 1'b1;
        end else if (len_q >= LenW'(MAX_NAME_LEN)) begin
          ovf_d    = 1'b1;
          failed_d = 1'b1;
        end else begin
          name_we = (depth_q < DepthW'(MAX_DEPTH));
          len_d   = len_q + 1'b1;
        end
      end
    end

    // End of a tag: pop, push or self-close
    if (do_finish) begin
      if (closing_q) begin
        if ((depth_q == '0) || mism_q || (len_q != top_len)) begin
          failed_d = 1'b1;
        end else begin
          depth_d   = depth_q - 1'b1;
          phase_d   = PH_OUTSIDE;
          closing_d = 1'b0;
          len_d     = '0;
          mism_d    = 1'b0;
        end
      end else if (!self_close && (depth_q >= DepthW'(MAX_DEPTH))) begin
        ovf_d    = 1'b1;
        failed_d = 1'b1;
      end else begin
        if (!self_close) begin
          len_we  = 1'b1;
          if ((depth_q == '0) && (root_q < 2'd2)) root_d = root_q + 1'b1;
          depth_d = depth_q + 1'b1;
        end
        phase_d   = PH_OUTSIDE;
        closing_d = 1'b0;
        len_d     = '0;
        mism_d    = 1'b0;
      end
    end

    // Verdict, then back to the reset state for the next document
    if (advance && in_end_q) begin
      cut_off   = (phase_d == PH_AFTER_LT) || (phase_d == PH_NAME) ||
                  (phase_d == PH_ATTR) || (phase_d == PH_SLASH);
      out_vld_d = 1'b1;
      wf_d      = !failed_d && !cut_off && (depth_d == '0) && (root_d == 2'd1);
      cap_d     = ovf_d;
      phase_d   = PH_OUTSIDE;
      qseen_d   = 1'b0;
      closing_d = 1'b0;
      len_d     = '0;
      mism_d    = 1'b0;
      depth_d   = '0;
      root_d    = '0;
      failed_d  = 1'b0;
      ovf_d     = 1'b0;
    end
  end

  // Store addresses: writes at the free slot, reads at the next top of stack
  always_comb begin
    logic [DepthW-1:0] next_top;
    next_top   = depth_d - 1'b1;
    name_waddr = NameAw'(NameAw'(depth_q[TopW-1:0]) * NameAw'(MAX_NAME_LEN)) +
                 NameAw'(len_q[ColW-1:0]);
    name_raddr = NameAw'(NameAw'(next_top[TopW-1:0]) * NameAw'(MAX_NAME_LEN)) +
                 NameAw'(len_d[ColW-1:0]);
    len_waddr  = depth_q[TopW-1:0];
    len_raddr  = next_top[TopW-1:0];
  end

  mtnc_ram #(
    .Width(8),
    .Depth(NameD)
  ) u_name_ram (
    .clk_i  (clk_i),
    .we_i   (name_we),
    .waddr_i(name_waddr),
    .wdata_i(in_byte_q),
    .raddr_i(name_raddr),
    .rdata_o(name_rd)
  );

  mtnc_ram #(
    .Width(LenW),
    .Depth(MAX_DEPTH)
  ) u_len_ram (
    .clk_i  (clk_i),
    .we_i   (len_we),
    .waddr_i(len_waddr),
    .wdata_i(len_q),
    .raddr_i(len_raddr),
    .rdata_o(len_rd)
  );

  // Bypass for a length written and read at the same slot in one cycle
  always_ff @(posedge clk_i) begin
    byp_q      <= len_we && (len_waddr == len_raddr);
    byp_data_q <= len_q;
  end

  // Input beat payload
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata[7:0];
      in_pres_q <= s_axis_tuser;
      in_end_q  <= s_axis_tlast;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    wf_q  <= wf_d;
    cap_q <= cap_d;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      phase_q   <= PH_OUTSIDE;
      qseen_q   <= 1'b0;
      closing_q <= 1'b0;
      len_q     <= '0;
      mism_q    <= 1'b0;
      depth_q   <= '0;
      root_q    <= '0;
      failed_q  <= 1'b0;
      ovf_q     <= 1'b0;
    end else begin
      if (s_axis_tready) in_vld_q <= s_axis_tvalid;
      out_vld_q <= out_vld_d;
      phase_q   <= phase_d;
      qseen_q   <= qseen_d;
      closing_q <= closing_d;
      len_q     <= len_d;
      mism_q    <= mism_d;
      depth_q   <= depth_d;
      root_q    <= root_d;
      failed_q  <= failed_d;
      ovf_q     <= ovf_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OutDataW - 2){1'b0}}, cap_q, wf_q};

  // Checks
  `include "assert_macros.svh"

  `ASSERT_NEVER(a_depth_bound, clk_i, rst_ni, depth_q > DepthW'(MAX_DEPTH), "stack depth past bound")
  `ASSERT_NEVER(a_root_sat, clk_i, rst_ni, root_q == 2'd3, "root count past saturation")
  `ASSERT_CLK(a_verdict_src, clk_i, rst_ni, $rose(m_axis_tvalid) |-> $past(advance && in_end_q), "verdict without end beat")
  `ASSERT_CLK(a_fail_sticky, clk_i, rst_ni, (failed_q && !(advance && in_end_q)) |=> failed_q, "failure cleared mid document")

endmodule
